// ===== src/ctp_pkg.sv =====
// Shared types, constants and codes of the CO2 trend predictor.
`default_nettype none
package ctp_pkg;

  localparam int WINDOW_POINTS_DEF = 6;
  localparam int MIN_POINTS        = 3;
  localparam int QUOT_BITS         = 9;

  localparam int PPM_W      = 16;
  localparam int CODE_W     = 3;
  localparam int MIN_W      = 8;
  localparam int SLOPE_W    = 8;
  localparam int HORIZON_W  = 8;
  localparam int INTERVAL_W = 6;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  localparam logic [PPM_W-1:0]      TARGET_RST   = 16'd1000;
  localparam logic [SLOPE_W-1:0]    SLOPE_RST    = 8'd5;
  localparam logic [HORIZON_W-1:0]  HORIZON_RST  = 8'd120;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 6'd5;

  typedef enum logic [CODE_W-1:0] {
    TREND_NONE        = 3'd0,
    TREND_STABLE      = 3'd1,
    TREND_RISING      = 3'd2,
    TREND_RISING_SLOW = 3'd3,
    TREND_VENT_SOON   = 3'd4,
    TREND_DROPPING    = 3'd5
  } trend_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET   = 2'd0,
    REG_SLOPE    = 2'd1,
    REG_HORIZON  = 2'd2,
    REG_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_RECORD  = 1'b0,
    OP_PREDICT = 1'b1
  } opcode_t;

  typedef struct packed {
    logic rec_we;
    logic acc_clr;
    logic acc_en;
    logic none_en;
    logic prod_en;
    logic diff_en;
    logic lim_en;
    logic cls_en;
    logic mul1_en;
    logic mul2_en;
    logic dchk_en;
    logic div_en;
    logic fin_en;
    logic out_load;
  } ctp_cmd_t;

  typedef struct packed {
    logic few;
    logic acc_last;
    logic rising;
    logic div_last;
    logic out_free;
  } ctp_sts_t;

endpackage
`default_nettype wire

// ===== src/ctp_ctrl.sv =====
// Sequencer of the CO2 trend predictor: steps the datapath through one item.
`default_nettype none
module ctp_ctrl import ctp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire opcode_t  in_opcode,
  input  wire logic     in_sensor_ready,
  input  wire ctp_sts_t sts,
  output ctp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_PROD, S_DIFF, S_LIM, S_CLS, S_MUL1, S_MUL2,
    S_DCHK, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   accept;

  assign in_tready = in_tready_r;
  assign accept    = in_tvalid && in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_RECORD) begin
            cmd.rec_we = in_sensor_ready;
          end else if (sts.few) begin
            cmd.none_en = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            cmd.acc_clr = 1'b1;
            state_nxt   = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.acc_last) state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_LIM;
      end
      S_LIM: begin
        cmd.lim_en = 1'b1;
        state_nxt  = S_CLS;
      end
      S_CLS: begin
        cmd.cls_en = 1'b1;
        state_nxt  = sts.rising ? S_MUL1 : S_OUT;
      end
      S_MUL1: begin
        cmd.mul1_en = 1'b1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2_en = 1'b1;
        state_nxt   = S_DCHK;
      end
      S_DCHK: begin
        cmd.dchk_en = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule
`default_nettype wire

// ===== src/ctp_dp.sv =====
// Datapath of the CO2 trend predictor: sample window, serial sums, trend math.
`default_nettype none
module ctp_dp import ctp_pkg::*; #(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ctp_cmd_t               cmd,
  output ctp_sts_t                    sts,
  input  wire logic [PPM_W-1:0]       in_ppm,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   out_tready,
  output logic                        out_tvalid,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int W       = WINDOW_POINTS;
  localparam int IDX_W   = $clog2(W);
  localparam int CNT_W   = $clog2(W + 1);
  localparam int SX_MAX  = W * (W - 1) / 2;
  localparam int SX2_MAX = (W - 1) * W * (2 * W - 1) / 6;
  localparam int SX_W    = $clog2(SX_MAX + 1);
  localparam int SX2_W   = $clog2(SX2_MAX + 1);
  localparam int SY_W    = PPM_W + CNT_W;
  localparam int SXY_W   = PPM_W + SX_W;
  localparam int P1_W    = CNT_W + SXY_W;
  localparam int P2_W    = SX_W + SY_W;
  localparam int DEN_W   = CNT_W + SX2_W;
  localparam int P4_W    = 2 * SX_W;
  localparam int NUM_W   = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int LIM_W   = SLOPE_W + DEN_W;
  localparam int CW      = (NUM_W > LIM_W + 1) ? NUM_W : LIM_W + 1;
  localparam int T_W     = INTERVAL_W + PPM_W;
  localparam int DVD_W   = T_W + DEN_W;
  localparam int DV_W    = NUM_W - 1 + QUOT_BITS - 1;
  localparam int BIG_W   = NUM_W - 1 + QUOT_BITS;
  localparam int CMP_W   = (DVD_W > BIG_W) ? DVD_W : BIG_W;
  localparam int DST_W   = $clog2(QUOT_BITS);
  localparam int PAD_W   = OUT_TDATA_W - CODE_W - MIN_W - PPM_W;

  logic [PPM_W-1:0]      win_r [W];
  logic [IDX_W-1:0]      wp_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [PPM_W-1:0]      target_r;
  logic [SLOPE_W-1:0]    slope_r;
  logic [HORIZON_W-1:0]  horizon_r;
  logic [INTERVAL_W-1:0] interval_r;

  logic [IDX_W-1:0]      rd_idx_r, step_r;
  logic [SY_W-1:0]       sy_r;
  logic [SXY_W-1:0]      sxy_r;
  logic [SX_W-1:0]       sx_r;
  logic [SX2_W-1:0]      sx2_r;
  logic [PPM_W-1:0]      cur_r;
  logic [P1_W-1:0]       p1_r;
  logic [P2_W-1:0]       p2_r;
  logic [DEN_W-1:0]      p3_r;
  logic [P4_W-1:0]       p4_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]      den_r;
  logic [LIM_W-1:0]      lim_r;
  logic [PPM_W-1:0]      remain_r;
  logic [T_W-1:0]        t_r;
  logic [DVD_W-1:0]      rem_r;
  logic [DV_W-1:0]       dv_r;
  logic [QUOT_BITS-1:0]  q_r;
  logic                  big_r;
  logic [DST_W-1:0]      dstep_r;

  trend_t                code_r;
  logic [MIN_W-1:0]      min_r;
  logic [PPM_W-1:0]      rep_r;
  logic                  out_valid_r;
  trend_t                out_code_r;
  logic [MIN_W-1:0]      out_min_r;
  logic [PPM_W-1:0]      out_cur_r;

  logic [IDX_W:0]        base_full;
  logic [IDX_W-1:0]      base_idx;
  logic [PPM_W-1:0]      y;
  logic signed [CW-1:0]  num_s, lim_s;
  logic                  rising, dropping;
  logic [NUM_W-2:0]      num_mag;
  logic                  div_ge;

  assign base_full = (IDX_W+1)'(wp_r) + (IDX_W+1)'(W) - (IDX_W+1)'(cnt_r);
  assign base_idx  = (base_full >= (IDX_W+1)'(W)) ? IDX_W'(base_full - (IDX_W+1)'(W))
                                                  : IDX_W'(base_full);
  assign y         = win_r[rd_idx_r];
  assign num_s     = CW'(num_r);
  assign lim_s     = $signed(CW'(lim_r));
  assign rising    = (num_s > lim_s) && (cur_r < target_r);
  assign dropping  = num_s < -lim_s;
  assign num_mag   = num_r[NUM_W-2:0];
  assign div_ge    = CMP_W'(rem_r) >= CMP_W'(dv_r);

  assign sts.few      = cnt_r < CNT_W'(MIN_POINTS);
  assign sts.acc_last = step_r == IDX_W'(cnt_r - CNT_W'(1));
  assign sts.rising   = rising;
  assign sts.div_last = dstep_r == '0;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), out_cur_r, out_min_r, out_code_r};

  always_ff @(posedge clk) begin
    if (cmd.rec_we) begin
      win_r[wp_r] <= in_ppm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      cnt_r       <= '0;
      target_r    <= TARGET_RST;
      slope_r     <= SLOPE_RST;
      horizon_r   <= HORIZON_RST;
      interval_r  <= INTERVAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rec_we) begin
        wp_r <= (wp_r == IDX_W'(W - 1)) ? '0 : wp_r + IDX_W'(1);
        if (cnt_r != CNT_W'(W)) cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TARGET:   target_r   <= cfg_data[PPM_W-1:0];
          REG_SLOPE:    slope_r    <= cfg_data[SLOPE_W-1:0];
          REG_HORIZON:  horizon_r  <= cfg_data[HORIZON_W-1:0];
          REG_INTERVAL: interval_r <= cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      rd_idx_r <= base_idx;
      step_r   <= '0;
      sy_r     <= '0;
      sxy_r    <= '0;
      sx_r     <= '0;
      sx2_r    <= '0;
    end
    if (cmd.acc_en) begin
      sy_r     <= sy_r + SY_W'(y);
      sxy_r    <= sxy_r + SXY_W'(step_r) * SXY_W'(y);
      sx_r     <= sx_r + SX_W'(step_r);
      sx2_r    <= sx2_r + SX2_W'(step_r) * SX2_W'(step_r);
      cur_r    <= y;
      step_r   <= step_r + IDX_W'(1);
      rd_idx_r <= (rd_idx_r == IDX_W'(W - 1)) ? '0 : rd_idx_r + IDX_W'(1);
    end
    if (cmd.prod_en) begin
      p1_r <= P1_W'(cnt_r) * P1_W'(sxy_r);
      p2_r <= P2_W'(sx_r) * P2_W'(sy_r);
      p3_r <= DEN_W'(cnt_r) * DEN_W'(sx2_r);
      p4_r <= P4_W'(sx_r) * P4_W'(sx_r);
    end
    if (cmd.diff_en) begin
      num_r <= $signed(NUM_W'(p1_r)) - $signed(NUM_W'(p2_r));
      den_r <= p3_r - DEN_W'(p4_r);
    end
    if (cmd.lim_en) begin
      lim_r    <= LIM_W'(slope_r) * LIM_W'(den_r);
      remain_r <= target_r - cur_r;
    end
    if (cmd.mul1_en) begin
      t_r <= T_W'(interval_r) * T_W'(remain_r);
    end
    if (cmd.mul2_en) begin
      rem_r <= DVD_W'(t_r) * DVD_W'(den_r);
    end
    if (cmd.dchk_en) begin
      dv_r    <= DV_W'(num_mag) << (QUOT_BITS - 1);
      big_r   <= CMP_W'(rem_r) >= (CMP_W'(num_mag) << QUOT_BITS);
      q_r     <= '0;
      dstep_r <= DST_W'(QUOT_BITS - 1);
    end
    if (cmd.div_en) begin
      if (div_ge) rem_r <= DVD_W'(CMP_W'(rem_r) - CMP_W'(dv_r));
      q_r     <= {q_r[QUOT_BITS-2:0], div_ge};
      dv_r    <= dv_r >> 1;
      dstep_r <= dstep_r - DST_W'(1);
    end
    if (cmd.none_en) begin
      code_r <= TREND_NONE;
      min_r  <= '0;
      rep_r  <= '0;
    end
    if (cmd.cls_en) begin
      min_r <= '0;
      rep_r <= '0;
      if (rising) begin
        code_r <= TREND_RISING;
      end else if (dropping) begin
        code_r <= TREND_DROPPING;
      end else begin
        code_r <= TREND_STABLE;
        rep_r  <= cur_r;
      end
    end
    if (cmd.fin_en) begin
      priority if (big_r || (q_r > QUOT_BITS'(horizon_r))) begin
        code_r <= TREND_RISING_SLOW;
      end else if (q_r == '0) begin
        code_r <= TREND_VENT_SOON;
      end else begin
        code_r <= TREND_RISING;
        min_r  <= q_r[MIN_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_code_r <= code_r;
      out_min_r  <= min_r;
      out_cur_r  <= rep_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/co2_trend_predictor.sv =====
// Top level of the CO2 trend predictor: least-squares trend over recent samples.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: co2_ppm; in_tuser: opcode, sensor_ready
//  out_     out  out_tvalid/out_tready out_tdata: trend_code, minutes_left, current_ppm
//  cfg_     in   cfg_we               cfg_index, cfg_data
//
//  A predict word runs a serial sum over the stored samples, then the trend math for stable
//  or dropping, plus the 9-step restoring divider for rising; with fewer than three
//  samples it reports no trend directly.
//  rst_n is synchronous; in_tready rises in the cycle after reset is released.
//  A record word is taken while a result waits; a predict holds in its last
//  step until the output register is free.
`default_nettype none
module co2_trend_predictor import ctp_pkg::*; #(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] co2_ppm
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // [0] opcode, [1] sensor_ready
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [2:0] trend_code, [10:3] minutes_left,
                                                  // [26:11] current_ppm, [31:27] zero
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  ctp_cmd_t cmd;
  ctp_sts_t sts;

  ctp_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_opcode       (opcode_t'(in_tuser[0])),
    .in_sensor_ready (in_tuser[1]),
    .sts             (sts),
    .cmd             (cmd)
  );

  ctp_dp #(
    .WINDOW_POINTS (WINDOW_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_ppm     (in_tdata[PPM_W-1:0]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== src/ctp_checker.sv =====
// Port-level checks of the CO2 trend predictor, bound to the top level.
`default_nettype none
module ctp_checker import ctp_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("handshake active right after reset");

  a_minutes_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[2:0] == TREND_RISING) == (out_tdata[10:3] != '0)))
    else $error("minutes field does not match trend code");

  a_current_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != TREND_STABLE) |-> out_tdata[26:11] == '0)
    else $error("current level reported with a non-stable code");

endmodule

bind co2_trend_predictor ctp_checker u_ctp_checker (.*);
`default_nettype wire
